### rtl/frc_pkg.sv
// Shared types and constants of the frame receiver.
package frc_pkg;

  localparam int NUM_DEV_REGS = 4;
  localparam int ADDR_W = 5;
  localparam int POS_W = 9;

  localparam logic [7:0] SYNC_FIRST     = 8'hAA;
  localparam logic [7:0] SYNC_SECOND    = 8'h55;
  localparam int         ERROR_BIT_IDX  = 7;
  localparam logic [7:0] CTRL_REGISTER  = 8'h10;
  localparam logic [7:0] CTRL_DATA      = 8'h11;
  localparam logic [7:0] FUNC_DISCOVERY = 8'h80;
  localparam logic [7:0] BROADCAST_SRC  = 8'hFF;
  localparam logic [7:0] DISCOVERY_LEN  = 8'd14;
  localparam logic [15:0] IDLE_LIMIT_RESET = 16'd50;

  // header byte positions
  localparam logic [POS_W-1:0] POS_SYNC0  = 9'd0;
  localparam logic [POS_W-1:0] POS_SYNC1  = 9'd1;
  localparam logic [POS_W-1:0] POS_SRC    = 9'd3;
  localparam logic [POS_W-1:0] POS_CTRL   = 9'd6;
  localparam logic [POS_W-1:0] POS_FUNC   = 9'd7;
  localparam logic [POS_W-1:0] POS_LEN    = 9'd8;
  localparam logic [POS_W-1:0] HEADER_LEN = 9'd9;

  // register indexes
  localparam logic [2:0] REG_DEV_A      = 3'd0;
  localparam logic [2:0] REG_DEV_B      = 3'd1;
  localparam logic [2:0] REG_DEV_C      = 3'd2;
  localparam logic [2:0] REG_DEV_D      = 3'd3;
  localparam logic [2:0] REG_DEV_COUNT  = 3'd4;
  localparam logic [2:0] REG_IDLE_LIMIT = 3'd5;

  // verdict codes
  localparam logic [2:0] ST_DELIVERED   = 3'd0;
  localparam logic [2:0] ST_DISCOVERED  = 3'd1;
  localparam logic [2:0] ST_UNKNOWN_BC  = 3'd2;
  localparam logic [2:0] ST_UNHANDLED   = 3'd3;
  localparam logic [2:0] ST_UNKNOWN_DEV = 3'd4;
  localparam logic [2:0] ST_BAD_HEADER  = 3'd5;
  localparam logic [2:0] ST_BAD_SUM     = 3'd6;

  typedef struct packed {
    logic [7:0] sender;
    logic [7:0] ctrl;
    logic [7:0] func;
    logic [7:0] len;
  } hdr_t;

endpackage

### rtl/frc_judge.sv
// End-of-frame verdict logic.
module frc_judge import frc_pkg::*; #(
  parameter int MAX_DEVICES = 4
) (
  input  logic                         sync_ok,
  input  logic [15:0]                  running_sum,
  input  logic [15:0]                  received,
  input  hdr_t                         hdr,
  input  logic [NUM_DEV_REGS-1:0][7:0] dev_addr,
  input  logic [2:0]                   dev_count,
  output logic [2:0]                   status
);

  localparam logic [2:0] MAX_DEV_CODE = 3'(MAX_DEVICES);

  logic [2:0] n_used;
  logic       found;

  always_comb begin
    n_used = (dev_count > MAX_DEV_CODE) ? MAX_DEV_CODE : dev_count;
    found = 1'b0;
    for (int i = 0; i < NUM_DEV_REGS; i++) begin
      if ((3'(i) < n_used) && (dev_addr[i] == hdr.sender)) begin
        found = 1'b1;
      end
    end
  end

  always_comb begin
    if (!sync_ok) begin
      status = ST_BAD_HEADER;
    end else if (running_sum != received) begin
      status = ST_BAD_SUM;
    end else if (hdr.sender == BROADCAST_SRC) begin
      if (hdr.ctrl == CTRL_REGISTER && hdr.func == FUNC_DISCOVERY &&
          hdr.len == DISCOVERY_LEN) begin
        status = ST_DISCOVERED;
      end else begin
        status = ST_UNKNOWN_BC;
      end
    end else if (!found) begin
      status = ST_UNKNOWN_DEV;
    end else if (hdr.ctrl == CTRL_DATA) begin
      status = ST_DELIVERED;
    end else begin
      status = ST_UNHANDLED;
    end
  end

endmodule

### rtl/frame_receiver_checksum.sv
// Top level of the length-prefixed frame receiver with additive checksum.
//
// Each input item is a received byte (kind 0) or a millisecond tick (kind 1).
// Bytes build a frame: 9-byte header (sync AA 55, source at byte 3, control
// at 6, function at 7, length at 8), payload, then a 16-bit big-endian sum of
// all preceding bytes. Every payload byte yields one result item as it
// arrives; the last checksum byte yields one verdict item and clears the
// frame. A set top bit in byte 1 drops the frame silently. Ticks advance an
// idle counter; the tick that finds it at or above idle_limit clears the
// partial frame. One item is accepted per clock: the frame state update and
// verdict are a single compare/add stage feeding one output register, and
// in_ready stays high while that register is empty or being drained, so the
// sustained rate is one item per cycle with no stall unless out_ready is low.
// Registers (APB, 32-bit, byte address 4*i): dev_addr_a..d, dev_count,
// idle_limit. Write them only while the block is idle.
module frame_receiver_checksum import frc_pkg::*; #(
  parameter int MAX_DEVICES = 4
) (
  input  logic              clk,
  input  logic              rst,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // input channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              kind,
  input  logic [7:0]        rx_byte,
  // output channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_kind,
  output logic [7:0]        payload_byte,
  output logic [7:0]        payload_index,
  output logic [2:0]        status,
  output logic [7:0]        source_addr,
  output logic [7:0]        control_code,
  output logic [7:0]        function_code,
  output logic [7:0]        payload_len,
  output logic [15:0]       computed_sum,
  output logic [15:0]       received_sum
);

  // config registers
  logic [NUM_DEV_REGS-1:0][7:0] dev_addr;
  logic [2:0]                   dev_count;
  logic [15:0]                  idle_limit;

  // frame state
  logic [POS_W-1:0] byte_pos, byte_pos_next;
  logic [15:0]      running_sum, running_sum_next;
  logic             sync_ok, sync_ok_next;
  hdr_t             hdr, hdr_next;
  logic [7:0]       sum_high, sum_high_next;
  logic [15:0]      idle_count, idle_count_next;

  logic             in_accept;
  logic             cfg_write;
  logic [2:0]       reg_idx;

  // result of the current item
  logic             res_valid;
  logic             res_kind;
  logic [7:0]       res_byte;
  logic [7:0]       res_index;
  logic [15:0]      received;
  logic [POS_W-1:0] end_pos;
  logic [POS_W-1:0] pay_off;
  logic [2:0]       verdict;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[ADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite;
  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  // ---------------- configuration port ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      dev_addr   <= '0;
      dev_count  <= '0;
      idle_limit <= IDLE_LIMIT_RESET;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_DEV_A:      dev_addr[0] <= pwdata[7:0];
        REG_DEV_B:      dev_addr[1] <= pwdata[7:0];
        REG_DEV_C:      dev_addr[2] <= pwdata[7:0];
        REG_DEV_D:      dev_addr[3] <= pwdata[7:0];
        REG_DEV_COUNT:  dev_count   <= pwdata[2:0];
        REG_IDLE_LIMIT: idle_limit  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DEV_A:      prdata = {24'd0, dev_addr[0]};
      REG_DEV_B:      prdata = {24'd0, dev_addr[1]};
      REG_DEV_C:      prdata = {24'd0, dev_addr[2]};
      REG_DEV_D:      prdata = {24'd0, dev_addr[3]};
      REG_DEV_COUNT:  prdata = {29'd0, dev_count};
      REG_IDLE_LIMIT: prdata = {16'd0, idle_limit};
      default:        prdata = 32'd0;
    endcase
  end

  // ---------------- verdict ----------------
  assign received = {sum_high, rx_byte};

  frc_judge #(
    .MAX_DEVICES(MAX_DEVICES)
  ) u_judge (
    .sync_ok     (sync_ok),
    .running_sum (running_sum),
    .received    (received),
    .hdr         (hdr),
    .dev_addr    (dev_addr),
    .dev_count   (dev_count),
    .status      (verdict)
  );

  // ---------------- per-item frame update ----------------
  assign end_pos = HEADER_LEN + {1'b0, hdr.len};
  assign pay_off = byte_pos - HEADER_LEN;

  always_comb begin
    byte_pos_next    = byte_pos;
    running_sum_next = running_sum;
    sync_ok_next     = sync_ok;
    hdr_next         = hdr;
    sum_high_next    = sum_high;
    idle_count_next  = idle_count;
    res_valid        = 1'b0;
    res_kind         = 1'b0;
    res_byte         = 8'd0;
    res_index        = 8'd0;

    if (kind) begin
      // tick: clear a stale frame once the idle limit is reached
      if (idle_count >= idle_limit) begin
        byte_pos_next    = '0;
        running_sum_next = '0;
        sync_ok_next     = 1'b0;
        hdr_next         = '0;
        sum_high_next    = '0;
        idle_count_next  = '0;
      end else begin
        idle_count_next = idle_count + 16'd1;
      end
    end else if (byte_pos >= HEADER_LEN && byte_pos == end_pos + 9'd1) begin
      // low checksum byte: verdict, frame cleared, idle count kept
      res_valid        = 1'b1;
      res_kind         = 1'b1;
      byte_pos_next    = '0;
      running_sum_next = '0;
      sync_ok_next     = 1'b0;
      hdr_next         = '0;
      sum_high_next    = '0;
    end else if (byte_pos == POS_SYNC1 && rx_byte[ERROR_BIT_IDX]) begin
      // error flag in byte 1: drop silently
      byte_pos_next    = '0;
      running_sum_next = '0;
      sync_ok_next     = 1'b0;
      hdr_next         = '0;
      sum_high_next    = '0;
    end else begin
      idle_count_next = '0;
      byte_pos_next   = byte_pos + 9'd1;
      if (byte_pos >= HEADER_LEN && byte_pos == end_pos) begin
        sum_high_next = rx_byte;
      end else begin
        running_sum_next = running_sum + {8'd0, rx_byte};
        case (byte_pos)
          POS_SYNC0: sync_ok_next    = (rx_byte == SYNC_FIRST);
          POS_SYNC1: sync_ok_next    = sync_ok && (rx_byte == SYNC_SECOND);
          POS_SRC:   hdr_next.sender = rx_byte;
          POS_CTRL:  hdr_next.ctrl   = rx_byte;
          POS_FUNC:  hdr_next.func   = rx_byte;
          POS_LEN:   hdr_next.len    = rx_byte;
          default: ;
        endcase
        if (byte_pos >= HEADER_LEN) begin
          res_valid = 1'b1;
          res_byte  = rx_byte;
          res_index = pay_off[7:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pos    <= '0;
      running_sum <= '0;
      sync_ok     <= 1'b0;
      hdr         <= '0;
      sum_high    <= '0;
      idle_count  <= '0;
    end else if (in_accept) begin
      byte_pos    <= byte_pos_next;
      running_sum <= running_sum_next;
      sync_ok     <= sync_ok_next;
      hdr         <= hdr_next;
      sum_high    <= sum_high_next;
      idle_count  <= idle_count_next;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept && res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // payload of the result item; header fields go out in both kinds
  always_ff @(posedge clk) begin
    if (in_accept && res_valid) begin
      out_kind      <= res_kind;
      payload_byte  <= res_byte;
      payload_index <= res_index;
      status        <= res_kind ? verdict : ST_DELIVERED;
      source_addr   <= hdr.sender;
      control_code  <= hdr.ctrl;
      function_code <= hdr.func;
      payload_len   <= hdr.len;
      computed_sum  <= res_kind ? running_sum : 16'd0;
      received_sum  <= res_kind ? received : 16'd0;
    end
  end

endmodule
